[src/dbd_pkg.sv]
// Shared types, constants and calendar tables for the day-difference pipeline.
package dbd_pkg;

   localparam int YEAR_W = 14;
   localparam int MONTH_W = 4;
   localparam int DAY_W = 5;
   localparam int DOY_W = 9;
   localparam int LEAPS_W = 13;
   localparam int DIFF_W = 23;
   localparam int PROD_W = 30;
   localparam int QUOT_W = 9;
   localparam int YSPAN_W = 23;
   localparam int SUM_W = 25;

   typedef logic [YEAR_W-1:0] year_type;
   typedef logic [MONTH_W-1:0] month_type;
   typedef logic [DAY_W-1:0] day_type;
   typedef logic [DOY_W-1:0] doy_type;
   typedef logic [LEAPS_W-1:0] leaps_type;
   typedef logic signed [DIFF_W-1:0] diff_type;
   typedef logic [PROD_W-1:0] prod_type;
   typedef logic [QUOT_W-1:0] quot_type;

   localparam year_type MAX_YEAR = 14'd10000;
   localparam int DIFF_LIMIT = 4194303;
   localparam int DAYS_PER_YEAR = 365;

   // floor(x / 100) == (x * DIV100_MAGIC) >> DIV100_SHIFT for x < 43690
   localparam logic [14:0] DIV100_MAGIC = 15'd20972;
   localparam int DIV100_SHIFT = 21;
   localparam logic [6:0] CENTURY = 7'd100;

   typedef struct packed {
      year_type  year;
      month_type month;
      day_type   day;
   } date_type;

   function automatic logic [4:0] month_len(input month_type m, input logic leap);
      logic [4:0] len;
      case (m)
         4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
         4'd4, 4'd6, 4'd9, 4'd11:                     len = 5'd30;
         4'd2:                                        len = leap ? 5'd29 : 5'd28;
         default:                                     len = 5'd0;
      endcase
      return len;
   endfunction

   function automatic doy_type month_start(input month_type m);
      doy_type s;
      case (m)
         4'd1:    s = 9'd0;
         4'd2:    s = 9'd31;
         4'd3:    s = 9'd59;
         4'd4:    s = 9'd90;
         4'd5:    s = 9'd120;
         4'd6:    s = 9'd151;
         4'd7:    s = 9'd181;
         4'd8:    s = 9'd212;
         4'd9:    s = 9'd243;
         4'd10:   s = 9'd273;
         4'd11:   s = 9'd304;
         4'd12:   s = 9'd334;
         default: s = 9'd0;
      endcase
      return s;
   endfunction

endpackage

[src/dbd_year_calc.sv]
// Per-year leap flag and leap-year count before the year, via reciprocal multiplies.
module dbd_year_calc import dbd_pkg::*; (
   input  logic      clock,
   input  logic      load,
   input  year_type  year,
   output year_type  year_out,
   output logic      leap,
   output leaps_type leaps
);

   year_type year_ff;
   prod_type floor_prod_ff, ceil100_prod_ff, ceil400_prod_ff;
   prod_type floor_prod_in, ceil100_prod_in, ceil400_prod_in;
   logic [14:0] plus99, plus399_q4;
   logic [15:0] plus399;
   quot_type q_floor, q_ceil100, q_ceil400;
   logic [15:0] century_base;
   logic [12:0] ceil4;

   assign plus99 = {1'b0, year} + 15'd99;
   assign plus399 = {2'b00, year} + 16'd399;
   assign plus399_q4 = {1'b0, plus399[15:2]};

   assign floor_prod_in = PROD_W'({1'b0, year} * DIV100_MAGIC);
   assign ceil100_prod_in = PROD_W'(plus99 * DIV100_MAGIC);
   assign ceil400_prod_in = PROD_W'(plus399_q4 * DIV100_MAGIC);

   always_ff @(posedge clock) begin
      if (load) begin
         year_ff <= year;
         floor_prod_ff <= floor_prod_in;
         ceil100_prod_ff <= ceil100_prod_in;
         ceil400_prod_ff <= ceil400_prod_in;
      end
   end

   assign q_floor = floor_prod_ff[DIV100_SHIFT +: QUOT_W];
   assign q_ceil100 = ceil100_prod_ff[DIV100_SHIFT +: QUOT_W];
   assign q_ceil400 = ceil400_prod_ff[DIV100_SHIFT +: QUOT_W];
   assign century_base = 16'(q_floor * CENTURY);

   // divisible by 4, and either not a century or a century divisible by 400
   assign leap = (year_ff[1:0] == 2'b00)
              && ((century_base != {2'b00, year_ff}) || (q_floor[1:0] == 2'b00));

   assign ceil4 = 13'(({1'b0, year_ff} + 15'd3) >> 2);
   assign leaps = ceil4 - LEAPS_W'(q_ceil100) + LEAPS_W'(q_ceil400);
   assign year_out = year_ff;

endmodule

[src/dbd_doy.sv]
// Day-of-year lookup and malformed-date detection for one date.
module dbd_doy import dbd_pkg::*; (
   input  month_type month,
   input  day_type   day,
   input  logic      leap,
   input  logic      over_max,
   output doy_type   doy,
   output logic      bad
);

   logic [4:0] len;
   logic month_ok, day_ok;

   assign len = month_len(month, leap);
   assign month_ok = (month >= 4'd1) && (month <= 4'd12);
   assign day_ok = (day != 5'd0) && (day <= len);
   assign bad = !(month_ok && day_ok);

   always_comb begin
      if (bad || over_max) begin
         doy = '0;
      end else begin
         doy = month_start(month) + DOY_W'(day)
             + DOY_W'(leap && (month > 4'd2));
      end
   end

endmodule

[src/days_between_dates_core.sv]
// Top level: four-stage pipeline giving the signed Gregorian day count between two dates.
//
// One word in per cycle while req_stall is low, one result out per word. Each word passes
// through the stage 1 to 4 registers in order, and rsp_valid is the stage 4 valid flag.
// Stage 1 orders the two dates, stage 2 holds the reciprocal products for the /100 and
// /400 leap counts, stage 3 forms leap flags, days of year and the whole-year span,
// stage 4 sums, signs and saturates into the output register. Each stage moves when the
// stage after it is empty or moving, so bubbles close up under rsp_stall and req_stall
// rises only with all four stages full. No state is kept between words.
module days_between_dates_core import dbd_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   input  logic      req_valid,
   output logic      req_stall,
   input  year_type  req_first_year,
   input  month_type req_first_month,
   input  day_type   req_first_day,
   input  year_type  req_second_year,
   input  month_type req_second_month,
   input  day_type   req_second_day,
   output logic      rsp_valid,
   input  logic      rsp_stall,
   output diff_type  rsp_day_difference,
   output logic      rsp_invalid_date
);

   logic v1_ff, v2_ff, v3_ff, v4_ff;
   logic load1, load2, load3, load4;

   date_type first_in, second_in;
   logic before_in;

   date_type lo1_ff, hi1_ff;
   logic neg1_ff, eq1_ff;

   month_type lo_month2_ff, hi_month2_ff;
   day_type lo_day2_ff, hi_day2_ff;
   logic neg2_ff, eq2_ff;
   year_type lo_year2, hi_year2;
   logic lo_leap2, hi_leap2;
   leaps_type lo_leaps2, hi_leaps2;

   doy_type lo_doy2, hi_doy2;
   logic lo_bad2, hi_bad2;
   logic [YSPAN_W-1:0] span_in;

   doy_type lo_doy3_ff, hi_doy3_ff;
   leaps_type lo_leaps3_ff, hi_leaps3_ff;
   logic [YSPAN_W-1:0] span3_ff;
   logic neg3_ff, eq3_ff, bad3_ff;

   logic signed [SUM_W-1:0] sum, signed_sum, sat_sum;
   diff_type diff_in;
   diff_type diff_ff;
   logic invalid_ff;

   // bubble-collapsing advance
   assign load4 = !v4_ff || !rsp_stall;
   assign load3 = !v3_ff || load4;
   assign load2 = !v2_ff || load3;
   assign load1 = !v1_ff || load2;
   assign req_stall = !load1;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else begin
         if (load1) v1_ff <= req_valid;
         if (load2) v2_ff <= v1_ff;
         if (load3) v3_ff <= v2_ff;
         if (load4) v4_ff <= v3_ff;
      end
   end

   // stage 1: ordering
   assign first_in = '{year: req_first_year, month: req_first_month, day: req_first_day};
   assign second_in = '{year: req_second_year, month: req_second_month, day: req_second_day};
   assign before_in = (first_in < second_in);

   always_ff @(posedge clock) begin
      if (load1) begin
         lo1_ff <= before_in ? first_in : second_in;
         hi1_ff <= before_in ? second_in : first_in;
         neg1_ff <= !before_in;
         eq1_ff <= (first_in == second_in);
      end
   end

   // stage 2: reciprocal products
   dbd_year_calc u_lo_year (
      .clock    (clock),
      .load     (load2),
      .year     (lo1_ff.year),
      .year_out (lo_year2),
      .leap     (lo_leap2),
      .leaps    (lo_leaps2)
   );

   dbd_year_calc u_hi_year (
      .clock    (clock),
      .load     (load2),
      .year     (hi1_ff.year),
      .year_out (hi_year2),
      .leap     (hi_leap2),
      .leaps    (hi_leaps2)
   );

   always_ff @(posedge clock) begin
      if (load2) begin
         lo_month2_ff <= lo1_ff.month;
         hi_month2_ff <= hi1_ff.month;
         lo_day2_ff <= lo1_ff.day;
         hi_day2_ff <= hi1_ff.day;
         neg2_ff <= neg1_ff;
         eq2_ff <= eq1_ff;
      end
   end

   // stage 3: leap flags, days of year, year span
   dbd_doy u_lo_doy (
      .month    (lo_month2_ff),
      .day      (lo_day2_ff),
      .leap     (lo_leap2),
      .over_max (lo_year2 > MAX_YEAR),
      .doy      (lo_doy2),
      .bad      (lo_bad2)
   );

   dbd_doy u_hi_doy (
      .month    (hi_month2_ff),
      .day      (hi_day2_ff),
      .leap     (hi_leap2),
      .over_max (hi_year2 > MAX_YEAR),
      .doy      (hi_doy2),
      .bad      (hi_bad2)
   );

   assign span_in = YSPAN_W'((hi_year2 - lo_year2) * 9'(DAYS_PER_YEAR));

   always_ff @(posedge clock) begin
      if (load3) begin
         lo_doy3_ff <= lo_doy2;
         hi_doy3_ff <= hi_doy2;
         lo_leaps3_ff <= lo_leaps2;
         hi_leaps3_ff <= hi_leaps2;
         span3_ff <= span_in;
         neg3_ff <= neg2_ff;
         eq3_ff <= eq2_ff;
         bad3_ff <= lo_bad2 || hi_bad2;
      end
   end

   // stage 4: sum, sign, saturate
   assign sum = $signed({2'b00, span3_ff})
              + $signed(SUM_W'(hi_leaps3_ff)) - $signed(SUM_W'(lo_leaps3_ff))
              + $signed(SUM_W'(hi_doy3_ff)) - $signed(SUM_W'(lo_doy3_ff));
   assign signed_sum = neg3_ff ? -sum : sum;

   always_comb begin
      if (signed_sum > SUM_W'(DIFF_LIMIT)) begin
         sat_sum = SUM_W'(DIFF_LIMIT);
      end else if (signed_sum < -SUM_W'(DIFF_LIMIT)) begin
         sat_sum = -SUM_W'(DIFF_LIMIT);
      end else begin
         sat_sum = signed_sum;
      end
   end

   assign diff_in = eq3_ff ? '0 : diff_type'(sat_sum[DIFF_W-1:0]);

   always_ff @(posedge clock) begin
      if (load4) begin
         diff_ff <= diff_in;
         invalid_ff <= bad3_ff;
      end
   end

   assign rsp_valid = v4_ff;
   assign rsp_day_difference = diff_ff;
   assign rsp_invalid_date = invalid_ff;

`ifndef SYNTHESIS
   a_stall_only_when_full: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (v1_ff && v2_ff && v3_ff && v4_ff))
      else $error("input stalled with a free pipeline stage");

   a_equal_gives_zero: assert property (@(posedge clock) disable iff (reset)
      (load4 && v3_ff && eq3_ff) |=> (rsp_day_difference == '0))
      else $error("equal dates gave a nonzero count");

   a_saturated_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_day_difference != diff_type'(23'h400000)))
      else $error("count outside saturation range");

   a_reset_empties: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid right after reset");
`endif

endmodule
